FILE: hdl/csv_sensor_frame_parser_unit_defines.svh
// assertion macros for the csv sensor frame parser
`ifndef CSV_SENSOR_FRAME_PARSER_UNIT_DEFINES_SVH
`define CSV_SENSOR_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSVP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CSVP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/csvp_pkg.sv
// shared types and constants for the csv sensor frame parser
package csvp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FIELD_W    = 31;
  localparam int unsigned OUT_FIELDS = 7;
  localparam int unsigned TAKEN_W    = 3;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned OUT_BITS   = OUT_FIELDS * FIELD_W + TAKEN_W;
  localparam int unsigned TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [FIELD_W-1:0] HMIN_RESET = 31'd800;
  localparam logic [TAKEN_W-1:0] TAKEN_MAX  = 3'd7;

  typedef enum logic [2:0] {
    TOK_SKIP,
    TOK_DIGIT,
    TOK_COMMA,
    TOK_MINUS,
    TOK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t           kind;
    logic [DIGIT_W-1:0]  digit;
    logic                last;
  } tok_t;

  typedef struct packed {
    logic [OUT_FIELDS-1:0][FIELD_W-1:0] fields;
    logic [TAKEN_W-1:0]                 taken;
  } frame_t;

endpackage

FILE: hdl/csvp_front.sv
// byte classifier and two-entry token queue
module csvp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csvp_pkg::BYTE_W-1:0]   in_byte,
  input  logic                          in_last,
  output logic                          q_valid,
  output csvp_pkg::tok_t                q_tok,
  input  logic                          q_pop
);

  csvp_pkg::tok_t tok_c;
  csvp_pkg::tok_t entry_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;

  always_comb begin
    tok_c.last  = in_last;
    tok_c.digit = '0;
    priority if (in_byte == csvp_pkg::CHAR_SPACE || in_byte == csvp_pkg::CHAR_CR ||
                 in_byte == csvp_pkg::CHAR_LF) begin
      tok_c.kind = csvp_pkg::TOK_SKIP;
    end else if (in_byte >= csvp_pkg::CHAR_ZERO && in_byte <= csvp_pkg::CHAR_NINE) begin
      tok_c.kind  = csvp_pkg::TOK_DIGIT;
      tok_c.digit = csvp_pkg::DIGIT_W'(in_byte - csvp_pkg::CHAR_ZERO);
    end else if (in_byte == csvp_pkg::CHAR_COMMA) begin
      tok_c.kind = csvp_pkg::TOK_COMMA;
    end else if (in_byte == csvp_pkg::CHAR_MINUS) begin
      tok_c.kind = csvp_pkg::TOK_MINUS;
    end else begin
      tok_c.kind = csvp_pkg::TOK_OTHER;
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_tok    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= tok_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: hdl/csvp_back.sv
// field parser: decimal accumulator, field store and frame snapshot
module csvp_back #(
  parameter int FIELD_COUNT = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [csvp_pkg::FIELD_W-1:0]  cfg_wr_data,
  input  logic                          q_valid,
  input  csvp_pkg::tok_t                q_tok,
  output logic                          q_pop,
  output logic                          frame_valid,
  input  logic                          frame_ready,
  output csvp_pkg::frame_t              frame
);

  localparam int PW   = $clog2(FIELD_COUNT + 1);
  localparam int NPAD = (FIELD_COUNT > csvp_pkg::OUT_FIELDS) ? FIELD_COUNT
                                                              : csvp_pkg::OUT_FIELDS;
  localparam int PROD_W = csvp_pkg::FIELD_W + 4;

  logic [csvp_pkg::FIELD_W-1:0] fields_r   [FIELD_COUNT];
  logic [csvp_pkg::FIELD_W-1:0] fields_nxt [FIELD_COUNT];
  logic [csvp_pkg::FIELD_W-1:0] pad_c      [NPAD];
  logic [PW-1:0]                pos_r, pos_proc, pos_nxt;
  logic [csvp_pkg::FIELD_W-1:0] acc_r, acc_proc, acc_nxt;
  logic                         inv_r, inv_proc, inv_nxt;
  logic                         neg_r, neg_proc, neg_nxt;
  logic                         stop_r, stop_nxt;
  logic [csvp_pkg::FIELD_W-1:0] hmin_r;
  logic [PROD_W-1:0]            prod_c;
  logic                         over_c;
  logic [csvp_pkg::FIELD_W-1:0] val_c;

  // acc * 10 + digit
  assign prod_c = PROD_W'({acc_r, 3'b000}) + PROD_W'({acc_r, 1'b0}) + PROD_W'(q_tok.digit);
  assign over_c = |prod_c[PROD_W-1:csvp_pkg::FIELD_W];
  assign val_c  = inv_r ? '0 : acc_r;

  always_comb begin
    for (int i = 0; i < FIELD_COUNT; i++) begin
      fields_nxt[i] = fields_r[i];
    end
    pos_proc = pos_r;
    acc_proc = acc_r;
    inv_proc = inv_r;
    neg_proc = neg_r;
    stop_nxt = stop_r;
    if (!stop_r) begin
      unique case (q_tok.kind)
        csvp_pkg::TOK_COMMA: begin
          priority if (!inv_r && neg_r && (acc_r != '0)) begin
            stop_nxt = 1'b1;
          end else if (pos_r >= PW'(FIELD_COUNT)) begin
            stop_nxt = 1'b1;
          end else if ((pos_r == '0) && (val_c < hmin_r)) begin
            stop_nxt = 1'b1;
          end else begin
            for (int i = 0; i < FIELD_COUNT; i++) begin
              if (pos_r == PW'(i)) begin
                fields_nxt[i] = val_c;
              end
            end
            pos_proc = pos_r + PW'(1);
            acc_proc = '0;
            inv_proc = 1'b0;
            neg_proc = 1'b0;
          end
        end
        csvp_pkg::TOK_DIGIT: begin
          if (over_c) begin
            inv_proc = 1'b1;
            acc_proc = '0;
          end else if (!inv_r) begin
            acc_proc = prod_c[csvp_pkg::FIELD_W-1:0];
          end
        end
        csvp_pkg::TOK_MINUS: begin
          if (!neg_r && !inv_r && (acc_r == '0)) begin
            neg_proc = 1'b1;
          end else begin
            inv_proc = 1'b1;
          end
        end
        csvp_pkg::TOK_OTHER: begin
          inv_proc = 1'b1;
        end
        default: begin
        end
      endcase
    end

    pos_nxt = pos_proc;
    acc_nxt = acc_proc;
    inv_nxt = inv_proc;
    neg_nxt = neg_proc;
    if (q_tok.last) begin
      pos_nxt  = '0;
      acc_nxt  = '0;
      inv_nxt  = 1'b0;
      neg_nxt  = 1'b0;
      stop_nxt = 1'b0;
    end

    for (int i = 0; i < NPAD; i++) begin
      pad_c[i] = '0;
    end
    for (int i = 0; i < FIELD_COUNT; i++) begin
      pad_c[i] = fields_nxt[i];
    end
    for (int i = 0; i < csvp_pkg::OUT_FIELDS; i++) begin
      frame.fields[i] = pad_c[i];
    end
    frame.taken = (pos_proc > PW'(7)) ? csvp_pkg::TAKEN_MAX
                                      : csvp_pkg::TAKEN_W'(pos_proc);
  end

  assign frame_valid = q_valid && q_tok.last;
  assign q_pop       = q_valid && (!q_tok.last || frame_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
        fields_r[i] <= '0;
      end
      pos_r  <= '0;
      acc_r  <= '0;
      inv_r  <= 1'b0;
      neg_r  <= 1'b0;
      stop_r <= 1'b0;
      hmin_r <= csvp_pkg::HMIN_RESET;
    end else begin
      if (cfg_wr_en) begin
        hmin_r <= cfg_wr_data;
      end
      if (q_pop) begin
        for (int i = 0; i < FIELD_COUNT; i++) begin
          fields_r[i] <= fields_nxt[i];
        end
        pos_r  <= pos_nxt;
        acc_r  <= acc_nxt;
        inv_r  <= inv_nxt;
        neg_r  <= neg_nxt;
        stop_r <= stop_nxt;
      end
    end
  end

endmodule

FILE: hdl/csvp_out.sv
// frame hold stage, checksum compare and output register
module csvp_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          frame_valid,
  output logic                          frame_ready,
  input  csvp_pkg::frame_t              frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csvp_pkg::TDATA_W-1:0]  out_data,
  output logic                          out_ok
);

  csvp_pkg::frame_t              frame_r;
  logic                          a_valid_r;
  logic                          b_valid_r;
  logic [csvp_pkg::TDATA_W-1:0]  data_r;
  logic                          ok_r;
  logic [csvp_pkg::SUM_W-1:0]    sum_c;
  logic                          ok_c;
  logic                          a_ready;
  logic                          b_ready;

  // wrapped sum of all fields but the check field
  assign sum_c = csvp_pkg::SUM_W'(frame_r.fields[0]) + csvp_pkg::SUM_W'(frame_r.fields[1])
               + csvp_pkg::SUM_W'(frame_r.fields[2]) + csvp_pkg::SUM_W'(frame_r.fields[4])
               + csvp_pkg::SUM_W'(frame_r.fields[5]) + csvp_pkg::SUM_W'(frame_r.fields[6]);
  assign ok_c  = (sum_c == csvp_pkg::SUM_W'(frame_r.fields[3]));

  assign b_ready     = !b_valid_r || out_ready;
  assign a_ready     = !a_valid_r || b_ready;
  assign frame_ready = a_ready;
  assign out_valid   = b_valid_r;
  assign out_data    = data_r;
  assign out_ok      = ok_r;

  always_ff @(posedge clk) begin
    if (a_ready && frame_valid) begin
      frame_r <= frame;
    end
    if (b_ready && a_valid_r) begin
      data_r <= csvp_pkg::TDATA_W'({frame_r.taken, frame_r.fields});
      ok_r   <= ok_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= frame_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

endmodule

FILE: hdl/csv_sensor_frame_parser_unit.sv
// top level of the csv sensor frame parser
//
// in_*: one ascii character per word in in_tdata, in_tlast on the final
// character of a chunk. out_*: one word per chunk, sent after its last
// character, with the seven stored fields, the field count and the checksum
// flag. cfg_wr_en/cfg_wr_data write the least accepted header value.
// a character is accepted every cycle while the two-entry token queue has
// room; the parser pops one token per cycle unless a chunk-end token waits
// for the frame hold, so the sustained rate is one word per cycle while the
// receiver keeps up. a chunk's end passes the token queue, the frame hold
// and the checksum register before out_tvalid rises. a stalled receiver
// first fills the frame hold and output registers, then holds the parser
// on its next chunk-end token and then the queue; in_tready then drops.
// reset clears the stored fields, the parse state and the valid flags of both
// pipeline registers and sets the header minimum to 800.
`include "csv_sensor_frame_parser_unit_defines.svh"

module csv_sensor_frame_parser_unit #(
  parameter int FIELD_COUNT = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,    // data_byte
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // header_value, channel_a, channel_b, check_value, time_first, time_second,
  // time_between, fields_taken, zero fill
  output logic [csvp_pkg::TDATA_W-1:0]  out_tdata,
  output logic                          out_tuser,   // checksum_ok
  input  logic                          cfg_wr_en,
  input  logic [csvp_pkg::FIELD_W-1:0]  cfg_wr_data
);

  logic                        q_valid;
  logic                        q_pop;
  csvp_pkg::tok_t              q_tok;
  logic                        frame_valid;
  logic                        frame_ready;
  csvp_pkg::frame_t            frame;
  logic [csvp_pkg::SUM_W-1:0]  out_sum;
  logic                        out_sum_ok;

  csvp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_valid  (q_valid),
    .q_tok    (q_tok),
    .q_pop    (q_pop)
  );

  csvp_back #(
    .FIELD_COUNT (FIELD_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_tok       (q_tok),
    .q_pop       (q_pop),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  csvp_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata),
    .out_ok      (out_tuser)
  );

  // checksum recomputed from the output word
  assign out_sum    = 32'(out_tdata[30:0]) + 32'(out_tdata[61:31]) + 32'(out_tdata[92:62])
                    + 32'(out_tdata[154:124]) + 32'(out_tdata[185:155])
                    + 32'(out_tdata[216:186]);
  assign out_sum_ok = (out_sum == 32'(out_tdata[123:93]));

  `CSVP_ASSERT_IMP(a_full_has_data, !in_tready, q_valid, "queue full but reports empty")
  `CSVP_ASSERT_NXT(a_tok_held, q_valid && !q_pop, q_valid, "unpopped token lost from queue")
  `CSVP_ASSERT_IMP(a_checksum, out_tvalid, out_tuser == out_sum_ok, "checksum flag wrong")

endmodule

FILE: tb/csvp_frame_checker.sv
// checker for the csv sensor frame parser: predicts each chunk's result word and compares it
`timescale 1ns / 100ps

module csvp_frame_checker #(
  parameter int SLOTS = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic                          in_tlast,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [csvp_pkg::TDATA_W-1:0]  out_tdata,
  input  logic                          out_tuser,
  input  logic                          cfg_wr_en,
  input  logic [csvp_pkg::FIELD_W-1:0]  cfg_wr_data,
  output int                            fail_count,
  output int                            frames_pending
);

  localparam logic [csvp_pkg::FIELD_W-1:0] FIELD_MAX = '1;

  typedef struct packed {
    logic                                                sum_ok;
    logic [csvp_pkg::TAKEN_W-1:0]                        taken;
    logic [csvp_pkg::OUT_FIELDS*csvp_pkg::FIELD_W-1:0]   flds;
  } frame_due_t;

  frame_due_t                   frames_due[$];
  logic [csvp_pkg::FIELD_W-1:0] slot [csvp_pkg::OUT_FIELDS];
  int                           slot_cnt;
  logic [csvp_pkg::FIELD_W-1:0] accum;
  logic                         accum_bad;
  logic                         accum_neg;
  logic                         chunk_dead;
  logic [csvp_pkg::FIELD_W-1:0] hdr_min;
  string                        field_name [csvp_pkg::OUT_FIELDS] = '{"header_value",
                                  "channel_a", "channel_b", "check_value", "time_first",
                                  "time_second", "time_between"};

  initial begin
    fail_count = 0;
    frames_pending = 0;
  end

  task automatic report(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void clear_field();
    accum = '0;
    accum_bad = 1'b0;
    accum_neg = 1'b0;
  endfunction

  function automatic void close_field();
    logic [csvp_pkg::FIELD_W-1:0] v;
    v = accum_bad ? '0 : accum;
    if ((!accum_bad && accum_neg && accum != '0) || slot_cnt >= SLOTS ||
        (slot_cnt == 0 && v < hdr_min)) begin
      chunk_dead = 1'b1;
    end else begin
      slot[slot_cnt] = v;
      slot_cnt++;
      clear_field();
    end
  endfunction

  function automatic void feed_char(input logic [7:0] c);
    longint grown;
    if (c == csvp_pkg::CHAR_SPACE || c == csvp_pkg::CHAR_CR || c == csvp_pkg::CHAR_LF) return;
    if (c >= csvp_pkg::CHAR_ZERO && c <= csvp_pkg::CHAR_NINE) begin
      grown = longint'(accum) * 10 + longint'(c - csvp_pkg::CHAR_ZERO);
      if (grown > longint'(FIELD_MAX)) begin
        accum_bad = 1'b1;
        accum = '0;
      end else if (!accum_bad) begin
        accum = csvp_pkg::FIELD_W'(grown);
      end
      return;
    end
    if (c == csvp_pkg::CHAR_MINUS && !accum_neg && !accum_bad && accum == '0) accum_neg = 1'b1;
    else accum_bad = 1'b1;
  endfunction

  function automatic void end_chunk();
    frame_due_t  e;
    logic [31:0] sum;
    sum = {1'b0, slot[0]} + {1'b0, slot[1]} + {1'b0, slot[2]} + {1'b0, slot[4]} +
          {1'b0, slot[5]} + {1'b0, slot[6]};
    for (int i = 0; i < csvp_pkg::OUT_FIELDS; i++)
      e.flds[i*csvp_pkg::FIELD_W +: csvp_pkg::FIELD_W] = slot[i];
    e.taken = (slot_cnt > 7) ? csvp_pkg::TAKEN_MAX : csvp_pkg::TAKEN_W'(slot_cnt);
    e.sum_ok = (sum == {1'b0, slot[3]});
    frames_due.push_back(e);
    slot_cnt = 0;
    clear_field();
    chunk_dead = 1'b0;
  endfunction

  function automatic void parse_word(input logic [7:0] c, input logic lst);
    if (!chunk_dead) begin
      if (c == csvp_pkg::CHAR_COMMA) close_field();
      else feed_char(c);
    end
    if (lst) end_chunk();
  endfunction

  task automatic check_frame();
    frame_due_t                   e;
    logic [csvp_pkg::FIELD_W-1:0] got;
    if (frames_due.size() == 0) begin
      report($sformatf("result word with no frame pending, tdata %h", out_tdata));
      return;
    end
    e = frames_due.pop_front();
    for (int i = 0; i < csvp_pkg::OUT_FIELDS; i++) begin
      got = out_tdata[i*csvp_pkg::FIELD_W +: csvp_pkg::FIELD_W];
      if (got !== e.flds[i*csvp_pkg::FIELD_W +: csvp_pkg::FIELD_W])
        report($sformatf("%s expected %0d got %0d", field_name[i],
                         e.flds[i*csvp_pkg::FIELD_W +: csvp_pkg::FIELD_W], got));
    end
    if (out_tdata[csvp_pkg::OUT_FIELDS*csvp_pkg::FIELD_W +: csvp_pkg::TAKEN_W] !== e.taken)
      report($sformatf("fields_taken expected %0d got %0d", e.taken,
                       out_tdata[csvp_pkg::OUT_FIELDS*csvp_pkg::FIELD_W +: csvp_pkg::TAKEN_W]));
    if (out_tuser !== e.sum_ok)
      report($sformatf("checksum_ok expected %0b got %0b", e.sum_ok, out_tuser));
    if (out_tdata[csvp_pkg::TDATA_W-1:csvp_pkg::OUT_BITS] !== '0)
      report($sformatf("zero fill expected 0 got %h",
                       out_tdata[csvp_pkg::TDATA_W-1:csvp_pkg::OUT_BITS]));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_min = csvp_pkg::HMIN_RESET;
      foreach (slot[i]) slot[i] = '0;
      slot_cnt = 0;
      clear_field();
      chunk_dead = 1'b0;
      frames_due.delete();
    end else begin
      if (out_tvalid && out_tready) check_frame();
      if (cfg_wr_en) hdr_min = cfg_wr_data;
      if (in_tvalid && in_tready) parse_word(in_tdata, in_tlast);
    end
    frames_pending = frames_due.size();
  end

endmodule

FILE: tb/tb.sv
// testbench top for the csv sensor frame parser: stimulus, stalls, watchdog and verdict
`timescale 1ns / 100ps

module tb;

  localparam int                           WATCH_LIMIT   = 3000;
  localparam int                           SETTLE_CYCLES = 8;
  localparam int                           PHASE_WORDS   = 270;
  localparam int                           PHASES        = 5;
  localparam logic [csvp_pkg::FIELD_W-1:0] HDR_TOP       = '1;

  typedef enum int {
    DEF_NONE,
    DEF_NEG,
    DEF_LOW_HEADER,
    DEF_JUNK,
    DEF_HUGE,
    DEF_TWO_MINUS,
    DEF_MID_MINUS,
    DEF_NEG_ZERO,
    DEF_SHORT
  } defect_t;

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata    = '0;
  logic                           in_tlast    = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  logic [csvp_pkg::TDATA_W-1:0]   out_tdata;
  logic                           out_tuser;
  logic                           cfg_wr_en   = 1'b0;
  logic [csvp_pkg::FIELD_W-1:0]   cfg_wr_data = '0;

  int                             fail_count;
  int                             frames_pending;
  logic [7:0]                     txt[$];
  int                             burst_left  = 0;
  int                             words_sent  = 0;
  logic [csvp_pkg::FIELD_W-1:0]   hdr_floor   = csvp_pkg::HMIN_RESET;
  int                             idle_cycles = 0;
  int                             rx_tick     = 0;
  int                             rx_mode     = 0;

  always #1 clk = ~clk;

  csv_sensor_frame_parser_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  csvp_frame_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .frames_pending (frames_pending)
  );

  // receiver stall pattern, switching mode now and then
  always @(negedge clk) begin
    if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (rx_tick % 5 == 0);
      default: out_tready <= (rx_tick % 16) >= 6;
    endcase
    rx_tick++;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_word(input logic [7:0] b, input logic lst);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_chunk();
    if (txt.size() == 0) txt.push_back(csvp_pkg::CHAR_LF);
    foreach (txt[i]) push_word(txt[i], i == txt.size() - 1);
    words_sent += txt.size();
    txt.delete();
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (frames_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void add_dec(input logic [31:0] v);
    logic [7:0]  dg[$];
    logic [31:0] r;
    r = v;
    do begin
      dg.push_front(csvp_pkg::CHAR_ZERO + 8'(r % 10));
      r = r / 10;
    end while (r != 0);
    foreach (dg[i]) txt.push_back(dg[i]);
  endfunction

  function automatic void add_pad();
    case ($urandom_range(0, 11))
      0: txt.push_back(csvp_pkg::CHAR_SPACE);
      1: txt.push_back(csvp_pkg::CHAR_CR);
      2: txt.push_back(csvp_pkg::CHAR_LF);
      3: txt.push_back(csvp_pkg::CHAR_ZERO);
      default: ;
    endcase
  endfunction

  function automatic logic [csvp_pkg::FIELD_W-1:0] rand_val();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return csvp_pkg::FIELD_W'($urandom_range(0, 9));
      4, 5, 6:    return csvp_pkg::FIELD_W'($urandom_range(0, 999));
      7, 8:       return csvp_pkg::FIELD_W'($urandom);
      default:    return HDR_TOP - csvp_pkg::FIELD_W'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [csvp_pkg::FIELD_W-1:0] pick_header();
    longint span;
    longint off;
    span = longint'(HDR_TOP) - longint'(hdr_floor);
    off = ($urandom_range(0, 1) == 0) ? longint'($urandom_range(0, 40)) : longint'($urandom);
    if (off > span) off = off % (span + 1);
    return csvp_pkg::FIELD_W'(longint'(hdr_floor) + off);
  endfunction

  function automatic void build_frame(input defect_t defect);
    logic [csvp_pkg::FIELD_W-1:0] v [csvp_pkg::OUT_FIELDS];
    logic [31:0]                  sum;
    int                           where;
    int                           nf;
    v[0] = pick_header();
    for (int i = 1; i < csvp_pkg::OUT_FIELDS; i++) v[i] = rand_val();
    sum = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]} + {1'b0, v[4]} + {1'b0, v[5]} +
          {1'b0, v[6]};
    v[3] = sum[csvp_pkg::FIELD_W-1:0];
    if ($urandom_range(0, 4) == 0) v[3] = v[3] ^ (31'd1 << $urandom_range(0, 30));
    where = (defect == DEF_LOW_HEADER) ? 0 : $urandom_range(0, csvp_pkg::OUT_FIELDS - 1);
    nf = (defect == DEF_SHORT) ? where : csvp_pkg::OUT_FIELDS;
    for (int i = 0; i < nf; i++) begin
      add_pad();
      if (i != where || defect == DEF_NONE || defect == DEF_SHORT) begin
        add_dec(32'(v[i]));
      end else begin
        case (defect)
          DEF_NEG: begin
            txt.push_back(csvp_pkg::CHAR_MINUS);
            add_dec(32'(rand_val() | 31'd1));
          end
          DEF_LOW_HEADER: add_dec((hdr_floor == '0) ? 32'd0 :
                                  32'(longint'($urandom) % longint'(hdr_floor)));
          DEF_JUNK: begin
            add_dec(32'(v[i]));
            txt.push_back(8'($urandom));
          end
          DEF_HUGE: add_dec(32'h8000_0000 | $urandom);
          DEF_TWO_MINUS: begin
            txt.push_back(csvp_pkg::CHAR_MINUS);
            txt.push_back(csvp_pkg::CHAR_MINUS);
            add_dec(32'(v[i]));
          end
          DEF_MID_MINUS: begin
            add_dec(32'(v[i]));
            txt.push_back(csvp_pkg::CHAR_MINUS);
            add_dec($urandom_range(0, 99));
          end
          default: begin
            txt.push_back(csvp_pkg::CHAR_MINUS);
            txt.push_back(csvp_pkg::CHAR_ZERO);
          end
        endcase
      end
      txt.push_back(csvp_pkg::CHAR_COMMA);
    end
    case ($urandom_range(0, 4))
      0: ;
      1: begin
        txt.push_back(csvp_pkg::CHAR_CR);
        txt.push_back(csvp_pkg::CHAR_LF);
      end
      2: txt.push_back(csvp_pkg::CHAR_LF);
      3: add_dec(32'(rand_val()));
      default: begin
        add_dec(32'(rand_val()));
        txt.push_back(csvp_pkg::CHAR_COMMA);
        txt.push_back(csvp_pkg::CHAR_LF);
      end
    endcase
  endfunction

  task automatic random_chunk();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) build_frame(DEF_NONE);
    else if (pick < 9) build_frame(defect_t'($urandom_range(int'(DEF_NEG), int'(DEF_SHORT))));
    else repeat ($urandom_range(1, 10)) txt.push_back(8'($urandom));
    send_chunk();
  endtask

  initial begin
    logic [csvp_pkg::FIELD_W-1:0] floor_val;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // header at the minimum, signed zero, junk byte, negative field stops the chunk
    add_dec(800);
    txt.push_back(csvp_pkg::CHAR_COMMA);
    txt.push_back(csvp_pkg::CHAR_MINUS);
    txt.push_back(csvp_pkg::CHAR_ZERO);
    txt.push_back(csvp_pkg::CHAR_COMMA);
    txt.push_back(8'hFF);
    txt.push_back(csvp_pkg::CHAR_COMMA);
    txt.push_back(csvp_pkg::CHAR_MINUS);
    add_dec(5);
    txt.push_back(csvp_pkg::CHAR_COMMA);
    add_dec(9);
    send_chunk();
    // header one below the minimum
    add_dec(799);
    txt.push_back(csvp_pkg::CHAR_COMMA);
    txt.push_back(8'h00);
    send_chunk();
    // whitespace only
    txt.push_back(csvp_pkg::CHAR_SPACE);
    txt.push_back(csvp_pkg::CHAR_CR);
    txt.push_back(csvp_pkg::CHAR_LF);
    send_chunk();
    // lone comma, empty header
    txt.push_back(csvp_pkg::CHAR_COMMA);
    send_chunk();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: floor_val = '0;
          2: floor_val = HDR_TOP;
          3: floor_val = csvp_pkg::FIELD_W'($urandom);
          default: floor_val = csvp_pkg::FIELD_W'($urandom_range(0, 5000));
        endcase
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= floor_val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        hdr_floor = floor_val;
      end
      words_sent = 0;
      while (words_sent < PHASE_WORDS) random_chunk();
    end

    settle();
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
